[rtl/core/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared widths, constants and types of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int ByteW  = 8;
    localparam int UnitW  = 16;
    localparam int AccumW = 32;
    localparam int CntW   = 2;

    localparam logic [ByteW-1:0]  AsciiMax    = 8'h7f;
    localparam logic [ByteW-1:0]  ContMax     = 8'hbf;
    localparam logic [ByteW-1:0]  Lead2Max    = 8'hdf;
    localparam logic [ByteW-1:0]  Lead3Max    = 8'hef;
    localparam logic [ByteW-1:0]  ContMask    = 8'h3f;
    localparam logic [ByteW-1:0]  Lead2Mask   = 8'h1f;
    localparam logic [ByteW-1:0]  Lead3Mask   = 8'h0f;
    localparam logic [ByteW-1:0]  Lead4Mask   = 8'h07;
    localparam logic [1:0]        ContTag     = 2'b10;

    localparam logic [AccumW-1:0] MaxCodePoint = 32'h0010_ffff;
    localparam logic [AccumW-1:0] BmpMax       = 32'h0000_ffff;
    localparam logic [AccumW-1:0] SurrFirst    = 32'h0000_d800;
    localparam logic [AccumW-1:0] SurrLast     = 32'h0000_dfff;
    localparam logic [20:0]       SuppOffset   = 21'h01_0000;
    localparam logic [UnitW-1:0]  HighSurrBase = 16'hd800;
    localparam logic [UnitW-1:0]  LowSurrBase  = 16'hdc00;
    localparam logic [9:0]        TenBitMask   = 10'h3ff;

    // Number of units one byte leaves in the output stage
    localparam logic [CntW-1:0] CntNone   = 2'd0;
    localparam logic [CntW-1:0] CntSingle = 2'd1;
    localparam logic [CntW-1:0] CntPair   = 2'd2;

    typedef struct packed {
        logic [AccumW-1:0] accum;
        logic [CntW-1:0]   n_units;
        logic [UnitW-1:0]  hi_unit;
        logic [UnitW-1:0]  lo_unit;
    } dec_result_t;

endpackage

[rtl/core/u8u16_decode.sv]
// ----------------------------------------------------------------------------
// u8u16_decode
// Folds one UTF-8 byte into the code point accumulator and forms the UTF-16
// units that a finished character produces.
// ----------------------------------------------------------------------------
module u8u16_decode (
    input  logic [u8u16_pkg::ByteW-1:0]  byte_in,
    input  logic [u8u16_pkg::ByteW-1:0]  next_byte,
    input  logic [u8u16_pkg::AccumW-1:0] accum,
    output u8u16_pkg::dec_result_t       result
);
    import u8u16_pkg::*;

    logic [AccumW-1:0] cp;
    logic [20:0]       supp;
    logic              next_is_cont;

    always_comb begin
        priority if (byte_in <= AsciiMax) begin
            cp = {{(AccumW-ByteW){1'b0}}, byte_in};
        end else if (byte_in <= ContMax) begin
            cp = {accum[AccumW-7:0], byte_in[5:0] & ContMask[5:0]};
        end else if (byte_in <= Lead2Max) begin
            cp = {{(AccumW-ByteW){1'b0}}, byte_in & Lead2Mask};
        end else if (byte_in <= Lead3Max) begin
            cp = {{(AccumW-ByteW){1'b0}}, byte_in & Lead3Mask};
        end else begin
            cp = {{(AccumW-ByteW){1'b0}}, byte_in & Lead4Mask};
        end
    end

    assign next_is_cont = (next_byte[7:6] == ContTag);
    assign supp         = cp[20:0] - SuppOffset;

    always_comb begin
        result.accum   = cp;
        result.hi_unit = HighSurrBase | {6'd0, supp[19:10]};
        result.lo_unit = LowSurrBase | {6'd0, supp[9:0] & TenBitMask};
        result.n_units = CntNone;
        if (!next_is_cont && cp <= MaxCodePoint) begin
            if (cp > BmpMax) begin
                result.n_units = CntPair;
            end else if (cp < SurrFirst || cp > SurrLast) begin
                // single unit travels in the low slot
                result.n_units = CntSingle;
                result.lo_unit = cp[UnitW-1:0];
            end
        end
    end

endmodule

[rtl/core/utf8_to_utf16_transcoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Streaming UTF-8 to UTF-16 transcoder, one byte in, up to two units out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis carries one UTF-8 byte per item together with the
//   byte that follows it (0 after the last byte of the string). Output
//   channel m_axis carries UTF-16 code units; m_axis_tlast marks the final
//   unit caused by one input byte (low surrogate or single unit).
//   A byte is held in the input register, is decoded against the
//   code point accumulator, and its units are registered in the output
//   stage once that stage is free.
//   Bytes that finish no character, or finish an invalid one, give nothing.
//   Throughput is one byte per cycle while units are taken; a byte that
//   yields a surrogate pair holds the output stage until both units are
//   taken, so the following byte waits. The input register still takes
//   one byte while a result waits for m_axis_tready.
//   Reset clears the accumulator to zero and empties both stages.
//   When the receiver stalls, the pending unit holds and after one buffered
//   byte s_axis_tready drops.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [2*u8u16_pkg::ByteW-1:0] s_axis_tdata,  // byte_in, next_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [u8u16_pkg::UnitW-1:0]  m_axis_tdata,   // unit_out
    output logic                         m_axis_tlast    // last_unit
);
    import u8u16_pkg::*;

    logic              in_valid_reg;
    logic [ByteW-1:0]  byte_reg;
    logic [ByteW-1:0]  next_byte_reg;
    logic [AccumW-1:0] accum_reg;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic [UnitW-1:0]  hi_reg;
    logic [UnitW-1:0]  lo_reg;

    dec_result_t       dec;
    logic              out_free;
    logic              advance;
    logic              s_fire;
    logic              m_fire;

    u8u16_decode u_decode (
        .byte_in   (byte_reg),
        .next_byte (next_byte_reg),
        .accum     (accum_reg),
        .result    (dec)
    );

    assign m_fire        = m_axis_tvalid && m_axis_tready;
    assign out_free      = (cnt_reg == CntNone) || (cnt_reg == CntSingle && m_axis_tready);
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (cnt_reg != CntNone);
    assign m_axis_tdata  = (cnt_reg == CntPair) ? hi_reg : lo_reg;
    assign m_axis_tlast  = (cnt_reg == CntSingle);

    always_comb begin
        if (advance) begin
            cnt_next = dec.n_units;
        end else if (m_fire) begin
            cnt_next = cnt_reg - CntSingle;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= CntNone;
            accum_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                accum_reg <= dec.accum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            byte_reg      <= s_axis_tdata[ByteW-1:0];
            next_byte_reg <= s_axis_tdata[2*ByteW-1:ByteW];
        end
        if (advance) begin
            hi_reg <= dec.hi_unit;
            lo_reg <= dec.lo_unit;
        end
    end

    // Output stage never holds more than a surrogate pair
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output stage count out of range");

    // A unit that is not last is always a high surrogate
    a_high_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[15:10] == 6'b110110)
        else $error("non-last unit is not a high surrogate");

    // After the high surrogate is taken, the low surrogate follows
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tvalid && m_axis_tlast && m_axis_tdata[15:10] == 6'b110111)
        else $error("low surrogate missing after high surrogate");

    // A buffered byte is not lost while the output stage is busy
    a_hold_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(byte_reg))
        else $error("buffered byte dropped");

endmodule
